>>> rtl/slf_pkg.sv
// slf_pkg: shared constants for the session link state machine
// event, transmit, timer and register codes, register reset values, field widths
// no dependencies
package slf_pkg;

    localparam int LEN_BITS_DEF = 10;

    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int STATE_W = 3;
    localparam int KIND_W  = 2;
    localparam int TIMER_W = 2;
    localparam int CFG_IDX_W = 3;

    // event codes
    localparam logic [OP_W-1:0] EV_START   = 3'd0;
    localparam logic [OP_W-1:0] EV_STOP    = 3'd1;
    localparam logic [OP_W-1:0] EV_PAYLOAD = 3'd2;
    localparam logic [OP_W-1:0] EV_RX      = 3'd3;
    localparam logic [OP_W-1:0] EV_ERROR   = 3'd4;
    localparam logic [OP_W-1:0] EV_TIMEOUT = 3'd5;

    // transmit kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CTRL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

    // timer commands
    localparam logic [TIMER_W-1:0] TM_NONE    = 2'd0;
    localparam logic [TIMER_W-1:0] TM_RELOAD  = 2'd1;
    localparam logic [TIMER_W-1:0] TM_ENABLE  = 2'd2;
    localparam logic [TIMER_W-1:0] TM_DISABLE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SESSION_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTO_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_REQ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_CONF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_REQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_CONF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_REQ   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_CONF  = 3'd7;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_SESSION_ID = 8'd0;
    localparam logic [BYTE_W-1:0] RST_PROTO_ID   = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CONN_REQ   = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CONN_CONF  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_KEEP_REQ   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_KEEP_CONF  = 8'd3;
    localparam logic [BYTE_W-1:0] RST_DISC_REQ   = 8'd4;
    localparam logic [BYTE_W-1:0] RST_DISC_CONF  = 8'd5;

    localparam int CTRL_FRAME_LEN = 3;

endpackage

>>> rtl/session_link_fsm.sv
// session_link_fsm: session layer state machine of a serial link, depends on slf_pkg
// one event word in, one result word out, input register then result register
// throughput: one event word per cycle; input ready falls only while both registers
//   hold a word and the result word is not taken
// reset: asynchronous active low; disconnected, link disabled, default codes, both emptied
module session_link_fsm
#(
    parameter int LEN_BITS = slf_pkg::LEN_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                                  cfg_we,
    input  logic [slf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [slf_pkg::BYTE_W-1:0]            cfg_data,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // opcode, frame_proto, frame_ctrl, frame_len, zero fill
    input  logic [((19 + LEN_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // next_state, tx_kind, tx_ctrl, tx_id, tx_len, deliver_up, deliver_len,
    // timer_action, link_enabled, zero fill
    output logic [((26 + 2 * LEN_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import slf_pkg::*;

    localparam int IN_W      = OP_W + 2 * BYTE_W + LEN_BITS;
    localparam int OUT_W     = STATE_W + KIND_W + 2 * BYTE_W + (LEN_BITS + 1) + 1
                               + LEN_BITS + TIMER_W + 1;
    localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [STATE_W-1:0] {
        ST_DISC  = 3'd0,
        ST_HAND1 = 3'd1,
        ST_HAND2 = 3'd2,
        ST_HAND3 = 3'd3,
        ST_CON   = 3'd4,
        ST_CHECK = 3'd5,
        ST_HALF1 = 3'd6,
        ST_HALF2 = 3'd7
    } state_t;

    // highest field first, opcode in the lowest bits
    typedef struct packed {
        logic [LEN_BITS-1:0] frame_len;
        logic [BYTE_W-1:0]   frame_ctrl;
        logic [BYTE_W-1:0]   frame_proto;
        logic [OP_W-1:0]     opcode;
    } event_t;

    // highest field first, next_state in the lowest bits
    typedef struct packed {
        logic                link_enabled;
        logic [TIMER_W-1:0]  timer_action;
        logic [LEN_BITS-1:0] deliver_len;
        logic                deliver_up;
        logic [LEN_BITS:0]   tx_len;
        logic [BYTE_W-1:0]   tx_id;
        logic [BYTE_W-1:0]   tx_ctrl;
        logic [KIND_W-1:0]   tx_kind;
        logic [STATE_W-1:0]  next_state;
    } result_t;

    logic [BYTE_W-1:0] session_id_reg, proto_id_reg;
    logic [BYTE_W-1:0] conn_req_reg, conn_conf_reg, keep_req_reg;
    logic [BYTE_W-1:0] keep_conf_reg, disc_req_reg, disc_conf_reg;

    state_t  state_reg, state_next;
    logic    enabled_reg, enabled_next;
    logic    in_valid_reg;
    event_t  in_reg;
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic    advance;
    logic    ctl, dat, tmo_err;
    logic    send_ctrl, send_data, dlv;
    logic [BYTE_W-1:0]  ctrl_code;
    logic [TIMER_W-1:0] tm;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_id_reg <= RST_SESSION_ID;
            proto_id_reg   <= RST_PROTO_ID;
            conn_req_reg   <= RST_CONN_REQ;
            conn_conf_reg  <= RST_CONN_CONF;
            keep_req_reg   <= RST_KEEP_REQ;
            keep_conf_reg  <= RST_KEEP_CONF;
            disc_req_reg   <= RST_DISC_REQ;
            disc_conf_reg  <= RST_DISC_CONF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SESSION_ID: session_id_reg <= cfg_data;
                REG_PROTO_ID:   proto_id_reg   <= cfg_data;
                REG_CONN_REQ:   conn_req_reg   <= cfg_data;
                REG_CONN_CONF:  conn_conf_reg  <= cfg_data;
                REG_KEEP_REQ:   keep_req_reg   <= cfg_data;
                REG_KEEP_CONF:  keep_conf_reg  <= cfg_data;
                REG_DISC_REQ:   disc_req_reg   <= cfg_data;
                REG_DISC_CONF:  disc_conf_reg  <= cfg_data;
                default:        session_id_reg <= session_id_reg;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_reg       <= '0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                in_reg <= event_t'(s_axis_tdata[IN_W-1:0]);
            end
        end
    end

    assign ctl     = (in_reg.opcode == EV_RX) && (in_reg.frame_proto == proto_id_reg);
    assign dat     = (in_reg.opcode == EV_RX) && (in_reg.frame_proto != proto_id_reg);
    assign tmo_err = (in_reg.opcode == EV_TIMEOUT) || (in_reg.opcode == EV_ERROR);

    // transitions, first match wins in each state
    always_comb
    begin
        state_next   = state_reg;
        enabled_next = enabled_reg;
        send_ctrl    = 1'b0;
        send_data    = 1'b0;
        dlv          = 1'b0;
        ctrl_code    = '0;
        tm           = TM_NONE;
        case (state_reg)
            ST_DISC:
            begin
                if (in_reg.opcode == EV_START)
                begin
                    state_next = ST_HAND1; send_ctrl = 1'b1; ctrl_code = conn_req_reg;
                    tm = TM_ENABLE;
                end
            end
            ST_HAND1:
            begin
                if (ctl && in_reg.frame_ctrl == conn_req_reg)
                begin
                    state_next = ST_HAND2; send_ctrl = 1'b1; ctrl_code = conn_conf_reg;
                    tm = TM_RELOAD;
                end
                else if (ctl && in_reg.frame_ctrl == conn_conf_reg)
                begin
                    state_next = ST_HAND3; tm = TM_RELOAD;
                end
                else if (tmo_err)
                begin
                    state_next = ST_HAND1; send_ctrl = 1'b1; ctrl_code = conn_req_reg;
                    tm = TM_RELOAD;
                end
            end
            ST_HAND2:
            begin
                if (ctl && in_reg.frame_ctrl == disc_req_reg)
                begin
                    state_next = ST_HALF2; send_ctrl = 1'b1; ctrl_code = disc_req_reg;
                    tm = TM_RELOAD;
                end
                else if (ctl && in_reg.frame_ctrl == conn_conf_reg)
                begin
                    state_next = ST_CON; tm = TM_RELOAD; enabled_next = 1'b1;
                end
                else if (tmo_err)
                begin
                    state_next = ST_HAND1; send_ctrl = 1'b1; ctrl_code = conn_req_reg;
                    tm = TM_RELOAD;
                end
            end
            ST_HAND3:
            begin
                if (ctl && in_reg.frame_ctrl == conn_req_reg)
                begin
                    state_next = ST_CON; send_ctrl = 1'b1; ctrl_code = conn_conf_reg;
                    tm = TM_RELOAD; enabled_next = 1'b1;
                end
                else if (tmo_err)
                begin
                    state_next = ST_HAND1; send_ctrl = 1'b1; ctrl_code = conn_req_reg;
                    tm = TM_RELOAD;
                end
            end
            ST_CON:
            begin
                if (in_reg.opcode == EV_STOP)
                begin
                    state_next = ST_HALF1; send_ctrl = 1'b1; ctrl_code = disc_req_reg;
                    tm = TM_RELOAD;
                end
                else if (in_reg.opcode == EV_PAYLOAD)
                begin
                    send_data = 1'b1; tm = TM_RELOAD;
                end
                else if (dat)
                begin
                    dlv = 1'b1; tm = TM_RELOAD;
                end
                else if (ctl && in_reg.frame_ctrl == keep_req_reg)
                begin
                    send_ctrl = 1'b1; ctrl_code = keep_conf_reg; tm = TM_RELOAD;
                end
                else if (ctl && in_reg.frame_ctrl == disc_req_reg)
                begin
                    state_next = ST_HALF2; send_ctrl = 1'b1; ctrl_code = disc_req_reg;
                    tm = TM_RELOAD;
                end
                else if (in_reg.opcode == EV_TIMEOUT)
                begin
                    state_next = ST_CHECK; send_ctrl = 1'b1; ctrl_code = keep_req_reg;
                    tm = TM_RELOAD;
                end
                else if (in_reg.opcode == EV_ERROR)
                begin
                    state_next = ST_HAND1; send_ctrl = 1'b1; ctrl_code = conn_req_reg;
                    tm = TM_RELOAD;
                end
            end
            ST_CHECK:
            begin
                if (in_reg.opcode == EV_PAYLOAD)
                begin
                    send_data = 1'b1;
                end
                else if (ctl && in_reg.frame_ctrl == keep_req_reg)
                begin
                    send_ctrl = 1'b1; ctrl_code = keep_conf_reg;
                end
                else if (dat)
                begin
                    state_next = ST_CON; dlv = 1'b1; tm = TM_RELOAD;
                end
                else if (ctl && in_reg.frame_ctrl == keep_conf_reg)
                begin
                    state_next = ST_CON; tm = TM_RELOAD;
                end
                else if (ctl && in_reg.frame_ctrl == disc_req_reg)
                begin
                    state_next = ST_HALF2; send_ctrl = 1'b1; ctrl_code = disc_req_reg;
                    tm = TM_RELOAD;
                end
                else if (tmo_err)
                begin
                    state_next = ST_HAND1; send_ctrl = 1'b1; ctrl_code = conn_req_reg;
                    tm = TM_RELOAD;
                end
            end
            ST_HALF1:
            begin
                if (dat)
                begin
                    dlv = 1'b1;
                end
                else if (ctl && in_reg.frame_ctrl == keep_req_reg)
                begin
                    send_ctrl = 1'b1; ctrl_code = disc_req_reg;
                end
                else if (ctl && in_reg.frame_ctrl == disc_req_reg)
                begin
                    state_next = ST_DISC; send_ctrl = 1'b1; ctrl_code = disc_conf_reg;
                    tm = TM_DISABLE; enabled_next = 1'b0;
                end
                else if (tmo_err)
                begin
                    state_next = ST_DISC; tm = TM_DISABLE; enabled_next = 1'b0;
                end
            end
            ST_HALF2:
            begin
                if (ctl && in_reg.frame_ctrl == disc_req_reg)
                begin
                    send_ctrl = 1'b1; ctrl_code = disc_req_reg;
                end
                else if (ctl && in_reg.frame_ctrl == disc_conf_reg)
                begin
                    state_next = ST_DISC; tm = TM_DISABLE; enabled_next = 1'b0;
                end
                else if (tmo_err)
                begin
                    state_next = ST_DISC; tm = TM_DISABLE; enabled_next = 1'b0;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // result word
    always_comb
    begin
        out_next              = '0;
        out_next.next_state   = state_next;
        out_next.timer_action = tm;
        out_next.link_enabled = enabled_next;
        if (send_ctrl)
        begin
            out_next.tx_kind = KIND_CTRL;
            out_next.tx_ctrl = ctrl_code;
            out_next.tx_id   = session_id_reg;
            out_next.tx_len  = (LEN_BITS + 1)'(CTRL_FRAME_LEN);
        end
        else if (send_data)
        begin
            out_next.tx_kind = KIND_DATA;
            out_next.tx_id   = session_id_reg;
            out_next.tx_len  = {1'b0, in_reg.frame_len} + (LEN_BITS + 1)'(1);
        end
        if (dlv)
        begin
            out_next.deliver_up  = 1'b1;
            out_next.deliver_len = (in_reg.frame_len == '0) ? '0
                                   : in_reg.frame_len - LEN_BITS'(1);
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DISC;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            out_valid_reg <= 1'b1;
            out_reg       <= out_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_PAD_W'(out_reg);

    // result word tracks the state it reports
    a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.next_state == state_reg)
                          && (out_reg.link_enabled == enabled_reg))
        else $error("result word out of step with state");

    a_tx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.tx_kind == KIND_NONE)
            |-> (out_reg.tx_id == '0) && (out_reg.tx_len == '0) && (out_reg.tx_ctrl == '0))
        else $error("idle transmit fields not cleared");

    a_deliver_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.deliver_up |-> (out_reg.deliver_len == '0))
        else $error("deliver length without delivery");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("held event word lost");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg) && $stable(enabled_reg))
        else $error("state moved without an event");

endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for session_link_fsm, event words in, result words out
// predicts every result word, drives random stalls on both streams, checks field by field
// depends on slf_pkg and session_link_fsm
module testbench;

    import slf_pkg::*;

    localparam int LEN_W       = LEN_BITS_DEF;
    localparam int IN_W        = ((19 + LEN_W + 7) / 8) * 8;
    localparam int OUT_W       = ((26 + 2 * LEN_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;

    // opcodes that the block treats as matching nothing
    localparam logic [OP_W-1:0] EV_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] EV_SPARE_B = 3'd7;

    typedef enum logic [STATE_W-1:0]
    {
        S_DISC, S_HAND1, S_HAND2, S_HAND3, S_CON, S_CHECK, S_HALF1, S_HALF2
    } link_state_t;

    typedef struct packed
    {
        logic [STATE_W-1:0] next_state;
        logic [KIND_W-1:0]  tx_kind;
        logic [7:0]         tx_ctrl;
        logic [7:0]         tx_id;
        logic [LEN_W:0]     tx_len;
        logic               deliver_up;
        logic [LEN_W-1:0]   deliver_len;
        logic [TIMER_W-1:0] timer_action;
        logic               link_enabled;
    } session_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    // predicted copy of the block
    logic [7:0] cfg_reg [8];
    link_state_t link_state;
    logic link_en;

    session_result_t pending_results [$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int hold_requests = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;

    session_link_fsm dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic session_result_t ctrl_word(input logic [7:0] code,
                                                  input logic [TIMER_W-1:0] timer);
        session_result_t r;
        r = '0;
        r.tx_kind = KIND_CTRL;
        r.tx_ctrl = code;
        r.tx_id = cfg_reg[REG_SESSION_ID];
        r.tx_len = (LEN_W + 1)'(CTRL_FRAME_LEN);
        r.timer_action = timer;
        return r;
    endfunction

    function automatic session_result_t data_word(input logic [LEN_W-1:0] len,
                                                  input logic [TIMER_W-1:0] timer);
        session_result_t r;
        r = '0;
        r.tx_kind = KIND_DATA;
        r.tx_id = cfg_reg[REG_SESSION_ID];
        r.tx_len = {1'b0, len} + (LEN_W + 1)'(1);
        r.timer_action = timer;
        return r;
    endfunction

    function automatic session_result_t deliver_word(input logic [LEN_W-1:0] len,
                                                     input logic [TIMER_W-1:0] timer);
        session_result_t r;
        r = '0;
        r.deliver_up = 1'b1;
        // empty frame saturates at zero
        r.deliver_len = (len == '0) ? '0 : len - LEN_W'(1);
        r.timer_action = timer;
        return r;
    endfunction

    function automatic session_result_t next_session_result(input logic [OP_W-1:0] op,
                                                            input logic [7:0] proto,
                                                            input logic [7:0] code,
                                                            input logic [LEN_W-1:0] len);
        session_result_t r;
        link_state_t ns;
        logic ctl;
        logic dat;
        logic tmo_err;
        logic [7:0] cr;
        logic [7:0] cc;
        logic [7:0] kr;
        logic [7:0] kc;
        logic [7:0] dr;
        logic [7:0] dc;
        r = '0;
        ns = link_state;
        ctl = (op == EV_RX) && (proto == cfg_reg[REG_PROTO_ID]);
        dat = (op == EV_RX) && !ctl;
        tmo_err = (op == EV_TIMEOUT) || (op == EV_ERROR);
        cr = cfg_reg[REG_CONN_REQ];
        cc = cfg_reg[REG_CONN_CONF];
        kr = cfg_reg[REG_KEEP_REQ];
        kc = cfg_reg[REG_KEEP_CONF];
        dr = cfg_reg[REG_DISC_REQ];
        dc = cfg_reg[REG_DISC_CONF];
        case (link_state)
            S_DISC:
            begin
                if (op == EV_START)
                begin
                    ns = S_HAND1;
                    r = ctrl_word(cr, TM_ENABLE);
                end
            end
            S_HAND1:
            begin
                if (ctl && code == cr)
                begin
                    ns = S_HAND2;
                    r = ctrl_word(cc, TM_RELOAD);
                end
                else if (ctl && code == cc)
                begin
                    ns = S_HAND3;
                    r.timer_action = TM_RELOAD;
                end
                else if (tmo_err)
                begin
                    ns = S_HAND1;
                    r = ctrl_word(cr, TM_RELOAD);
                end
            end
            S_HAND2:
            begin
                if (ctl && code == dr)
                begin
                    ns = S_HALF2;
                    r = ctrl_word(dr, TM_RELOAD);
                end
                else if (ctl && code == cc)
                begin
                    ns = S_CON;
                    r.timer_action = TM_RELOAD;
                    link_en = 1'b1;
                end
                else if (tmo_err)
                begin
                    ns = S_HAND1;
                    r = ctrl_word(cr, TM_RELOAD);
                end
            end
            S_HAND3:
            begin
                if (ctl && code == cr)
                begin
                    ns = S_CON;
                    r = ctrl_word(cc, TM_RELOAD);
                    link_en = 1'b1;
                end
                else if (tmo_err)
                begin
                    ns = S_HAND1;
                    r = ctrl_word(cr, TM_RELOAD);
                end
            end
            S_CON:
            begin
                if (op == EV_STOP)
                begin
                    ns = S_HALF1;
                    r = ctrl_word(dr, TM_RELOAD);
                end
                else if (op == EV_PAYLOAD)
                    r = data_word(len, TM_RELOAD);
                else if (dat)
                    r = deliver_word(len, TM_RELOAD);
                else if (ctl && code == kr)
                    r = ctrl_word(kc, TM_RELOAD);
                else if (ctl && code == dr)
                begin
                    ns = S_HALF2;
                    r = ctrl_word(dr, TM_RELOAD);
                end
                else if (op == EV_TIMEOUT)
                begin
                    ns = S_CHECK;
                    r = ctrl_word(kr, TM_RELOAD);
                end
                else if (op == EV_ERROR)
                begin
                    // back to the handshake, enable flag kept
                    ns = S_HAND1;
                    r = ctrl_word(cr, TM_RELOAD);
                end
            end
            S_CHECK:
            begin
                if (op == EV_PAYLOAD)
                    r = data_word(len, TM_NONE);
                else if (ctl && code == kr)
                    r = ctrl_word(kc, TM_NONE);
                else if (dat)
                begin
                    ns = S_CON;
                    r = deliver_word(len, TM_RELOAD);
                end
                else if (ctl && code == kc)
                begin
                    ns = S_CON;
                    r.timer_action = TM_RELOAD;
                end
                else if (ctl && code == dr)
                begin
                    ns = S_HALF2;
                    r = ctrl_word(dr, TM_RELOAD);
                end
                else if (tmo_err)
                begin
                    ns = S_HAND1;
                    r = ctrl_word(cr, TM_RELOAD);
                end
            end
            S_HALF1:
            begin
                if (dat)
                    r = deliver_word(len, TM_NONE);
                else if (ctl && code == kr)
                    r = ctrl_word(dr, TM_NONE);
                else if (ctl && code == dr)
                begin
                    ns = S_DISC;
                    r = ctrl_word(dc, TM_DISABLE);
                    link_en = 1'b0;
                end
                else if (tmo_err)
                begin
                    ns = S_DISC;
                    r.timer_action = TM_DISABLE;
                    link_en = 1'b0;
                end
            end
            default:
            begin
                if (ctl && code == dr)
                    r = ctrl_word(dr, TM_NONE);
                else if ((ctl && code == dc) || tmo_err)
                begin
                    ns = S_DISC;
                    r.timer_action = TM_DISABLE;
                    link_en = 1'b0;
                end
            end
        endcase
        link_state = ns;
        r.next_state = ns;
        r.link_enabled = link_en;
        return r;
    endfunction

    task automatic send_event(input logic [OP_W-1:0] op, input logic [7:0] proto,
                              input logic [7:0] ctrl, input logic [LEN_W-1:0] len);
        int gap;
        logic [IN_W-1:0] word;
        gap = tx_gaps_on ? $urandom_range(0, 13) : 0;
        word = IN_W'({len, ctrl, proto, op});
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_results.push_back(next_session_result(op, proto, ctrl, len));
    endtask

    task automatic send_random_event(input bit guided);
        logic [OP_W-1:0] op;
        logic [7:0] proto;
        logic [7:0] ctrl;
        logic [LEN_W-1:0] len;
        int pick;
        case ($urandom_range(0, 7))
            0: len = '0;
            1: len = '1;
            default: len = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
        endcase
        ctrl = cfg_reg[CFG_IDX_W'($urandom_range(REG_CONN_REQ, REG_DISC_CONF))];
        proto = cfg_reg[REG_PROTO_ID];
        if (!guided)
        begin
            op = OP_W'($urandom_range(0, 7));
            ctrl = 8'($urandom);
            if ($urandom_range(0, 1))
                proto = 8'($urandom);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (link_state == S_DISC && pick < 70)
                op = EV_START;
            else if (pick < 40)
                op = EV_RX;
            else if (pick < 60)
            begin
                op = EV_RX;
                proto = proto ^ 8'($urandom_range(1, 255));
            end
            else if (pick < 75)
                op = EV_PAYLOAD;
            else if (pick < 85)
                op = EV_TIMEOUT;
            else if (pick < 90)
                op = EV_ERROR;
            else if (pick < 95)
                op = EV_STOP;
            else
                op = EV_START;
        end
        send_event(op, proto, ctrl, len);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_reg[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] sid, input logic [7:0] pid,
                                input logic [7:0] cr, input logic [7:0] cc,
                                input logic [7:0] kr, input logic [7:0] kc,
                                input logic [7:0] dr, input logic [7:0] dc);
        wait_drained();
        write_reg(REG_SESSION_ID, sid);
        write_reg(REG_PROTO_ID, pid);
        write_reg(REG_CONN_REQ, cr);
        write_reg(REG_CONN_CONF, cc);
        write_reg(REG_KEEP_REQ, kr);
        write_reg(REG_KEEP_CONF, kc);
        write_reg(REG_DISC_REQ, dr);
        write_reg(REG_DISC_CONF, dc);
    endtask

    // reset codes, one walk through every state except S_HALF2
    task automatic test_directed_session();
        logic [7:0] pid;
        pid = cfg_reg[REG_PROTO_ID];
        send_event(EV_STOP, pid, 8'h00, '0);
        send_event(EV_PAYLOAD, pid, 8'h00, '1);
        send_event(EV_RX, pid, cfg_reg[REG_CONN_REQ], '0);
        send_event(EV_ERROR, 8'hFF, 8'hFF, '1);
        send_event(EV_TIMEOUT, pid, 8'h00, '0);
        send_event(EV_SPARE_A, pid, cfg_reg[REG_CONN_REQ], '1);
        send_event(EV_SPARE_B, 8'hFF, 8'hFF, '1);
        send_event(EV_START, pid, 8'h00, '0);
        send_event(EV_RX, pid, cfg_reg[REG_CONN_REQ], 10'd3);
        send_event(EV_RX, pid, cfg_reg[REG_CONN_CONF], 10'd3);
        send_event(EV_PAYLOAD, pid, 8'h00, '0);
        send_event(EV_PAYLOAD, pid, 8'h00, '1);
        send_event(EV_RX, ~pid, 8'h00, '0);
        send_event(EV_RX, ~pid, 8'hFF, '1);
        send_event(EV_RX, pid, cfg_reg[REG_KEEP_REQ], 10'd3);
        send_event(EV_TIMEOUT, pid, 8'h00, '0);
        send_event(EV_PAYLOAD, pid, 8'h00, 10'd5);
        send_event(EV_RX, pid, cfg_reg[REG_KEEP_REQ], 10'd3);
        send_event(EV_RX, pid, cfg_reg[REG_KEEP_CONF], 10'd3);
        send_event(EV_ERROR, pid, 8'h00, '0);
        send_event(EV_RX, pid, cfg_reg[REG_CONN_CONF], 10'd3);
        send_event(EV_RX, pid, cfg_reg[REG_CONN_REQ], 10'd3);
        send_event(EV_STOP, pid, 8'h00, '0);
        send_event(EV_RX, ~pid, 8'h00, 10'd1);
        send_event(EV_RX, pid, cfg_reg[REG_KEEP_REQ], 10'd3);
        send_event(EV_RX, pid, cfg_reg[REG_DISC_REQ], 10'd3);
    endtask

    // every code equal, first match in each state wins
    task automatic test_equal_codes();
        program_regs(8'hFF, 8'hA5, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A);
        send_event(EV_START, 8'hA5, 8'h00, '0);
        send_event(EV_RX, 8'hA5, 8'h5A, 10'd3);
        send_event(EV_RX, 8'hA5, 8'h5A, 10'd3);
        send_event(EV_RX, 8'hA5, 8'h5A, 10'd3);
        send_event(EV_TIMEOUT, 8'hA5, 8'h00, '0);
        for (int n = 0; n < 15; n++)
            send_random_event(1'b1);
    endtask

    task automatic test_backpressure();
        program_regs(8'h3C, 8'hC3, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15);
        tx_gaps_on = 1'b0;
        hold_requests++;
        for (int n = 0; n < 30; n++)
            send_random_event(1'b1);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_pause_drain();
        for (int n = 0; n < 10; n++)
            send_random_event(1'b1);
        wait_drained();
        for (int n = 0; n < 10; n++)
            send_random_event(1'b1);
    endtask

    task automatic test_random_sessions();
        logic [7:0] c [6];
        for (int s = 0; s < 6; s++)
        begin
            for (int k = 0; k < 6; k++)
                c[k] = (s == 3) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            case (s)
                0: program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                1: program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                4: program_regs(RST_SESSION_ID, RST_PROTO_ID, RST_CONN_REQ, RST_CONN_CONF,
                                RST_KEEP_REQ, RST_KEEP_CONF, RST_DISC_REQ, RST_DISC_CONF);
                default: program_regs(8'($urandom), 8'($urandom),
                                      c[0], c[1], c[2], c[3], c[4], c[5]);
            endcase
            for (int n = 0; n < 175; n++)
            begin
                if (n % 35 == 0)
                begin
                    tx_gaps_on = $urandom_range(0, 3) != 0;
                    rx_gaps_on = $urandom_range(0, 3) != 0;
                end
                send_random_event($urandom_range(0, 3) != 0);
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin : result_monitor
        int stall;
        int holds_done;
        session_result_t got;
        session_result_t want;
        holds_done = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                stall = LONG_HOLD;
                holds_done++;
            end
            else
                stall = rx_gaps_on ? $urandom_range(0, 13) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            got.next_state   = m_axis_tdata[2:0];
            got.tx_kind      = m_axis_tdata[4:3];
            got.tx_ctrl      = m_axis_tdata[12:5];
            got.tx_id        = m_axis_tdata[20:13];
            got.tx_len       = m_axis_tdata[31:21];
            got.deliver_up   = m_axis_tdata[32];
            got.deliver_len  = m_axis_tdata[42:33];
            got.timer_action = m_axis_tdata[44:43];
            got.link_enabled = m_axis_tdata[45];
            if (pending_results.size() == 0)
            begin
                $error("result word with no prediction: %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("next_state", 16'(want.next_state), 16'(got.next_state));
                check_field("tx_kind", 16'(want.tx_kind), 16'(got.tx_kind));
                check_field("tx_ctrl", 16'(want.tx_ctrl), 16'(got.tx_ctrl));
                check_field("tx_id", 16'(want.tx_id), 16'(got.tx_id));
                check_field("tx_len", 16'(want.tx_len), 16'(got.tx_len));
                check_field("deliver_up", 16'(want.deliver_up), 16'(got.deliver_up));
                check_field("deliver_len", 16'(want.deliver_len), 16'(got.deliver_len));
                check_field("timer_action", 16'(want.timer_action),
                            16'(got.timer_action));
                check_field("link_enabled", 16'(want.link_enabled),
                            16'(got.link_enabled));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_reg[REG_SESSION_ID] = RST_SESSION_ID;
        cfg_reg[REG_PROTO_ID] = RST_PROTO_ID;
        cfg_reg[REG_CONN_REQ] = RST_CONN_REQ;
        cfg_reg[REG_CONN_CONF] = RST_CONN_CONF;
        cfg_reg[REG_KEEP_REQ] = RST_KEEP_REQ;
        cfg_reg[REG_KEEP_CONF] = RST_KEEP_CONF;
        cfg_reg[REG_DISC_REQ] = RST_DISC_REQ;
        cfg_reg[REG_DISC_CONF] = RST_DISC_CONF;
        link_state = S_DISC;
        link_en = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_session();
        test_equal_codes();
        test_backpressure();
        test_pause_drain();
        test_random_sessions();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> session_link_fsm.f
rtl/slf_pkg.sv
rtl/session_link_fsm.sv
verif/testbench.sv
